FILE: src/sitrd_pkg.sv
`default_nettype none

package sitrd_pkg;

    localparam int ALPHABET_DEPTH = 16;
    localparam int STORE_BYTES    = 16;
    localparam int CFG_W          = 64;
    localparam int NUM_W          = 32;
    localparam int CHAR_W         = 8;
    localparam int MAX_DIGITS     = 32;
    localparam int IDX_W          = $clog2(STORE_BYTES);
    localparam int LEN_W          = $clog2(STORE_BYTES + 1);
    localparam int DIGIT_W        = IDX_W;
    localparam int ND_W           = $clog2(MAX_DIGITS + 1);
    localparam int BUF_IDX_W      = $clog2(MAX_DIGITS);
    localparam int BITS_PER_CYC   = 8;
    localparam int DIV_STEPS      = NUM_W / BITS_PER_CYC;
    localparam int STEP_W         = $clog2(DIV_STEPS);

    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

    localparam logic REG_ALPHA_LOW  = 1'b0;
    localparam logic REG_ALPHA_HIGH = 1'b1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CHK  = 3'd1;
    localparam logic [2:0] ST_ZERO = 3'd2;
    localparam logic [2:0] ST_SIGN = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_EMIT = 3'd5;

endpackage

`default_nettype wire

FILE: src/signed_int_to_radix_digits_unit.sv
// Sequence: an alphabet check over the L alphabet bytes (L = alphabet length), then the
//   digits (D, up to 32) from a shared 8-bit-per-cycle restoring divider, then one
//   character out per cycle while the output does not stall, plus a leading '-' if negative.
//   Input stalls for the whole conversion.
// Reset (synchronous, active low) clears both alphabet registers, the sequencer and the
//   output valid; an empty alphabet is invalid, so numbers give no characters until set.
`default_nettype none

module signed_int_to_radix_digits_unit
    import sitrd_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic                    i_cfg_idx,
    input  wire logic [CFG_W-1:0]        i_cfg_data,
    input  wire logic                    i_valid,
    output logic                         o_stall,
    input  wire logic signed [NUM_W-1:0] i_number,
    output logic                         o_valid,
    input  wire logic                    i_stall,
    output logic [CHAR_W-1:0]            o_out_char,
    output logic                         o_last
);

    logic [CFG_W-1:0]     r_alpha_low, r_alpha_high;
    logic [2:0]           r_state, n_state;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic [NUM_W-1:0]     r_mag, n_mag;
    logic [DIGIT_W-1:0]   r_rem, n_rem;
    logic [STEP_W-1:0]    r_step, n_step;
    logic [ND_W-1:0]      r_nd, n_nd;
    logic [DIGIT_W-1:0]   r_buf [MAX_DIGITS];
    logic                 r_ovalid, n_ovalid;
    logic [CHAR_W-1:0]    r_ochar, n_ochar;
    logic                 r_olast, n_olast;
    logic                 r_neg;

    logic [2*CFG_W-1:0]   alpha;
    logic [LEN_W-1:0]     len;
    logic                 bad;
    logic [CHAR_W-1:0]    cur_byte;
    logic [NUM_W-1:0]     div_q;
    logic [DIGIT_W-1:0]   div_r;
    logic                 slot_free;
    logic                 buf_we;
    logic [BUF_IDX_W-1:0] rd_idx;
    logic [ND_W-1:0]      nd_m1;
    logic [NUM_W-1:0]     in_raw;

    assign alpha     = {r_alpha_high, r_alpha_low};
    assign slot_free = !r_ovalid || !i_stall;
    assign o_stall   = (r_state != ST_IDLE);
    assign o_valid   = r_ovalid;
    assign o_out_char = r_ochar;
    assign o_last    = r_olast;
    assign in_raw    = i_number;
    assign nd_m1     = r_nd - ND_W'(1);
    assign rd_idx    = nd_m1[BUF_IDX_W-1:0];

    always_comb begin
        len = LEN_W'(ALPHABET_DEPTH);
        for (int k = ALPHABET_DEPTH - 1; k >= 0; k--) begin
            if (alpha[k*CHAR_W +: CHAR_W] == '0) begin
                len = LEN_W'(k);
            end
        end
    end

    // byte r_idx against '+', '-' and every later byte of the alphabet
    always_comb begin
        cur_byte = alpha[r_idx*CHAR_W +: CHAR_W];
        bad = (cur_byte == CH_PLUS) || (cur_byte == CH_MINUS);
        for (int j = 0; j < ALPHABET_DEPTH; j++) begin
            if (LEN_W'(j) > LEN_W'(r_idx) && LEN_W'(j) < len
                    && alpha[j*CHAR_W +: CHAR_W] == cur_byte) begin
                bad = 1'b1;
            end
        end
    end

    // restoring division by the radix, BITS_PER_CYC quotient bits per cycle
    always_comb begin
        logic [DIGIT_W:0] rem;
        rem   = {1'b0, r_rem};
        div_q = r_mag;
        for (int b = 0; b < BITS_PER_CYC; b++) begin
            rem   = {rem[DIGIT_W-1:0], div_q[NUM_W-1]};
            div_q = {div_q[NUM_W-2:0], 1'b0};
            if (rem >= (DIGIT_W+1)'(len)) begin
                rem      = rem - (DIGIT_W+1)'(len);
                div_q[0] = 1'b1;
            end
        end
        div_r = rem[DIGIT_W-1:0];
    end

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_mag    = r_mag;
        n_rem    = r_rem;
        n_step   = r_step;
        n_nd     = r_nd;
        n_ovalid = r_ovalid && i_stall;
        n_ochar  = r_ochar;
        n_olast  = r_olast;
        buf_we   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_mag   = in_raw[NUM_W-1] ? (~in_raw + NUM_W'(1)) : in_raw;
                    n_idx   = '0;
                    n_rem   = '0;
                    n_step  = '0;
                    n_nd    = '0;
                    n_state = ST_CHK;
                end
            end
            ST_CHK: begin
                if (len < LEN_W'(2) || bad) begin
                    n_state = ST_IDLE;
                end else if (LEN_W'(r_idx) == len - LEN_W'(1)) begin
                    if (r_mag == '0) begin
                        n_state = ST_ZERO;
                    end else if (r_neg) begin
                        n_state = ST_SIGN;
                    end else begin
                        n_state = ST_DIV;
                    end
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            ST_ZERO: begin
                if (slot_free) begin
                    n_ovalid = 1'b1;
                    n_ochar  = alpha[CHAR_W-1:0];
                    n_olast  = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            ST_SIGN: begin
                if (slot_free) begin
                    n_ovalid = 1'b1;
                    n_ochar  = CH_MINUS;
                    n_olast  = 1'b0;
                    n_state  = ST_DIV;
                end
            end
            ST_DIV: begin
                n_mag  = div_q;
                n_rem  = div_r;
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    buf_we = 1'b1;
                    n_nd   = r_nd + ND_W'(1);
                    n_rem  = '0;
                    if (div_q == '0) begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    n_ovalid = 1'b1;
                    n_ochar  = alpha[r_buf[rd_idx]*CHAR_W +: CHAR_W];
                    n_olast  = (r_nd == ND_W'(1));
                    n_nd     = nd_m1;
                    if (r_nd == ND_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_ovalid     <= 1'b0;
            r_alpha_low  <= '0;
            r_alpha_high <= '0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_ALPHA_LOW:  r_alpha_low  <= i_cfg_data;
                    REG_ALPHA_HIGH: r_alpha_high <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_mag   <= n_mag;
        r_rem   <= n_rem;
        r_step  <= n_step;
        r_nd    <= n_nd;
        r_ochar <= n_ochar;
        r_olast <= n_olast;
        if (buf_we) begin
            r_buf[r_nd[BUF_IDX_W-1:0]] <= div_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_valid) begin
            r_neg <= in_raw[NUM_W-1];
        end
    end

endmodule

`default_nettype wire

FILE: verif/signed_int_to_radix_digits_unit_test.sv
`timescale 1ns / 1ps

typedef struct packed {
    logic [7:0] ch;
    logic       last;
} t_radix_char;

class digit_scoreboard;
    logic [63:0]  alpha_lo;
    logic [63:0]  alpha_hi;
    t_radix_char  want_q[$];
    int           errors;
    int           chars_seen;
    int           numbers_converted;
    int           max_chars;

    function new();
        alpha_lo = '0;
        alpha_hi = '0;
        errors = 0;
        chars_seen = 0;
        numbers_converted = 0;
        max_chars = 0;
    endfunction

    function logic [7:0] alpha_byte(int k);
        logic [63:0] word;
        word = (k < 8) ? alpha_lo : alpha_hi;
        return word[(k % 8) * 8 +: 8];
    endfunction

    // 0 when the alphabet is unusable
    function int radix_now();
        int          len;
        int          i;
        int          j;
        logic [7:0]  c;
        len = 0;
        while (len < sitrd_pkg::ALPHABET_DEPTH && len < sitrd_pkg::STORE_BYTES &&
               alpha_byte(len) != 8'h00)
            len++;
        if (len < 2)
            return 0;
        for (i = 0; i < len; i++) begin
            c = alpha_byte(i);
            if (c == sitrd_pkg::CH_PLUS || c == sitrd_pkg::CH_MINUS)
                return 0;
            for (j = i + 1; j < len; j++)
                if (alpha_byte(j) == c)
                    return 0;
        end
        return len;
    endfunction

    function void note_number(logic signed [31:0] n);
        int      r;
        longint  mag;
        int      dig[32];
        int      nd;
        int      k;
        r = radix_now();
        if (r == 0)
            return;
        numbers_converted++;
        if (n == 0) begin
            want_q.push_back('{alpha_byte(0), 1'b1});
            if (max_chars < 1)
                max_chars = 1;
            return;
        end
        mag = n;
        nd = 0;
        if (mag < 0) begin
            want_q.push_back('{sitrd_pkg::CH_MINUS, 1'b0});
            mag = -mag;
        end
        while (mag != 0) begin
            dig[nd] = int'(mag % r);
            mag = mag / r;
            nd++;
        end
        for (k = nd - 1; k >= 0; k--)
            want_q.push_back('{alpha_byte(dig[k]), k == 0});
        if (max_chars < nd + (n < 0))
            max_chars = nd + (n < 0);
    endfunction

    task report(string msg);
        errors++;
        if (errors <= 40)
            $display("mismatch at %0t: %s", $time, msg);
    endtask

    task check_char(logic [7:0] ch, logic last);
        t_radix_char w;
        chars_seen++;
        if (want_q.size() == 0) begin
            report($sformatf("unexpected char 0x%02h last=%0b", ch, last));
            return;
        end
        w = want_q.pop_front();
        if (ch !== w.ch)
            report($sformatf("char 0x%02h, want 0x%02h", ch, w.ch));
        if (last !== w.last)
            report($sformatf("last %0b, want %0b (char 0x%02h)", last, w.last, w.ch));
    endtask

    function int pending();
        return want_q.size();
    endfunction
endclass

module signed_int_to_radix_digits_unit_test;
    import sitrd_pkg::*;

    localparam int SETTLE_CYCLES = 250;
    localparam int HOLD_CYCLES   = 500;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic                     i_cfg_idx;
    logic [CFG_W-1:0]         i_cfg_data;
    logic                     i_valid;
    logic                     o_stall;
    logic signed [NUM_W-1:0]  i_number;
    logic                     o_valid;
    logic                     i_stall;
    logic [CHAR_W-1:0]        o_out_char;
    logic                     o_last;

    digit_scoreboard sb;
    int  send_idle_pct;
    int  recv_stall_pct;
    logic hold_req;
    int  hold_left;
    int  numbers_sent;
    int  settings_used;

    signed_int_to_radix_digits_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_number   (i_number),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out_char (o_out_char),
        .o_last     (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        i_stall <= 1'b0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req <= 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_char(o_out_char, o_last);
    end

    task automatic send_number(logic signed [31:0] n);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_number <= n;
        do
            @(posedge i_clk);
        while (o_stall);
        sb.note_number(n);
        numbers_sent++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_alphabet(logic [127:0] a);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= REG_ALPHA_LOW;
        i_cfg_data <= a[63:0];
        @(posedge i_clk);
        i_cfg_idx <= REG_ALPHA_HIGH;
        i_cfg_data <= a[127:64];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.alpha_lo = a[63:0];
        sb.alpha_hi = a[127:64];
        settings_used++;
    endtask

    function automatic logic [127:0] alpha_from_text(string s);
        logic [127:0] a;
        int           k;
        a = '0;
        for (k = 0; k < s.len(); k++)
            a[k * 8 +: 8] = s[k];
        return a;
    endfunction

    // distinct usable bytes, zero terminator when shorter than 16, random junk past it
    function automatic logic [127:0] random_alphabet(int len);
        logic [127:0] a;
        logic [255:0] used;
        logic [7:0]   c;
        int           k;
        a = {$urandom, $urandom, $urandom, $urandom};
        used = '0;
        used[0] = 1'b1;
        used[CH_PLUS] = 1'b1;
        used[CH_MINUS] = 1'b1;
        for (k = 0; k < len; k++) begin
            do
                c = 8'($urandom_range(255));
            while (used[c]);
            used[c] = 1'b1;
            a[k * 8 +: 8] = c;
        end
        if (len < 16)
            a[len * 8 +: 8] = 8'h00;
        return a;
    endfunction

    function automatic logic [127:0] broken_alphabet();
        logic [127:0] a;
        int           len;
        int           i;
        int           j;
        len = $urandom_range(2, 16);
        a = random_alphabet(len);
        case ($urandom_range(3))
            0: a[$urandom_range(1) * 8 +: 8] = 8'h00;
            1: a[$urandom_range(len - 1) * 8 +: 8] = CH_PLUS;
            2: a[$urandom_range(len - 1) * 8 +: 8] = CH_MINUS;
            default: begin
                i = $urandom_range(len - 2);
                j = $urandom_range(i + 1, len - 1);
                a[j * 8 +: 8] = a[i * 8 +: 8];
            end
        endcase
        return a;
    endfunction

    function automatic logic signed [31:0] random_number();
        logic signed [31:0] n;
        case ($urandom_range(5))
            0: n = $urandom;
            1: n = $urandom_range(40);
            2: n = -$signed($urandom_range(40));
            3: n = 32'sh8000_0000 + $urandom_range(3);
            4: n = 32'sh7FFF_FFFF - $urandom_range(3);
            default: begin
                n = $urandom >> $urandom_range(31);
                if ($urandom_range(1))
                    n = -n;
            end
        endcase
        return n;
    endfunction

    initial begin
        int ph;
        int k;
        int count;
        sb = new();
        numbers_sent = 0;
        settings_used = 0;
        hold_req <= 1'b0;
        send_idle_pct = 24;
        recv_stall_pct = 86;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= REG_ALPHA_LOW;
        i_cfg_data <= '0;
        i_valid <= 1'b0;
        i_number <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty alphabet after reset: nothing comes out
        send_number(0);
        send_number(5);
        send_number(-5);

        write_alphabet(alpha_from_text("01"));
        send_number(32'sh8000_0000);
        send_number(32'sh7FFF_FFFF);
        send_number(0);
        send_number(-1);
        send_number(1);

        write_alphabet(alpha_from_text("0123456789"));
        send_number(0);
        send_number(7);
        send_number(-7);
        send_number(10);
        send_number(-10);
        send_number(32'sh7FFF_FFFF);
        send_number(32'sh8000_0000);
        send_number(1000000000);

        write_alphabet(alpha_from_text("0123456789ABCDEF"));
        send_number(15);
        send_number(16);
        send_number(-16);
        send_number(255);
        send_number(32'sh7FFF_FFFF);
        send_number(32'sh8000_0000);

        write_alphabet(alpha_from_text("0+1"));
        send_number(-3);
        write_alphabet(alpha_from_text("-01"));
        send_number(3);
        write_alphabet(alpha_from_text("0120"));
        send_number(12);
        write_alphabet(alpha_from_text("7"));
        send_number(0);

        for (ph = 0; ph < 15; ph++) begin
            if (ph == 5) begin
                send_idle_pct = 86;
                recv_stall_pct = 24;
            end else if (ph == 10) begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            if (ph % 5 == 4) begin
                write_alphabet(broken_alphabet());
                count = 4;
            end else begin
                case (ph)
                    0:       write_alphabet(random_alphabet(2));
                    1:       write_alphabet(random_alphabet(16));
                    default: write_alphabet(random_alphabet($urandom_range(2, 16)));
                endcase
                count = 38;
            end
            for (k = 0; k < count; k++) begin
                if (ph == 12 && k == 5)
                    hold_req <= 1'b1;
                send_number(random_number());
            end
        end

        drain();
        $display("converted %0d of %0d numbers over %0d alphabet settings",
                 sb.numbers_converted, numbers_sent, settings_used);
        $display("compared %0d characters, up to %0d for one number",
                 sb.chars_seen, sb.max_chars);
        if (sb.errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
